/* sv/psc_pkg.sv */
// shared widths, register map and payload types of the pressure compensation core
package psc_pkg;

  localparam int unsigned RawW  = 24;
  localparam int unsigned CalW  = 16;
  localparam int unsigned SeaW  = 20;
  localparam int unsigned TempW = 19;
  localparam int unsigned PresW = 32;
  localparam int unsigned DepW  = 32;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    RegC1     = 3'd0,
    RegC2     = 3'd1,
    RegC3     = 3'd2,
    RegC4     = 3'd3,
    RegC5     = 3'd4,
    RegC6     = 3'd5,
    RegSeaRef = 3'd6
  } psc_reg_e;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic signed [PresW-1:0] pressure;
  } psc_res_t;

endpackage

/* sv/psc_if.sv */
// request and result channel interfaces of the pressure compensation core
interface psc_smp_if import psc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_pressure;
  logic [RawW-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface psc_res_if import psc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temp_centi;
  logic signed [PresW-1:0] pressure_deci_mbar;
  logic signed [DepW-1:0]  depth_mm;

  modport source (output valid, output temp_centi, output pressure_deci_mbar,
                  output depth_mm, input ready);
  modport sink   (input valid, input temp_centi, input pressure_deci_mbar,
                  input depth_mm, output ready);
endinterface

/* sv/psc_depth.sv */
// pipelined depth conversion: (p - sea_ref) * 1e7 / 10091043 truncated, with output register
module psc_depth import psc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  psc_res_t               in_i,
  input  logic [SeaW-1:0]        sea_ref_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output psc_res_t               out_o,
  output logic signed [DepW-1:0] depth_o
);

  localparam int unsigned NumStg     = 6;
  localparam int unsigned RecipShift = 34;
  localparam logic [23:0] DepthNum   = 24'd10000000;
  localparam logic [23:0] DepthDen   = 24'd10091043;
  localparam logic [33:0] DepthRecip =
    34'((64'd1 << RecipShift) * 64'd10000000 / 64'd10091043);

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] vld_in;
  logic [NumStg:0]   rdy;

  assign rdy[NumStg] = out_ready_i;
  for (genvar g = 0; g < NumStg; g++) begin : g_rdy
    assign rdy[g] = ~vld_q[g] | rdy[g+1];
  end
  assign vld_in      = {vld_q[NumStg-2:0], in_valid_i};
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (rdy[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  // d1: difference to the surface reference
  logic signed [32:0] x_d;
  logic signed [32:0] d1_x_q;
  psc_res_t           d1_res_q;
  assign x_d = 33'(in_i.pressure) - $signed({13'b0, sea_ref_i});

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      d1_x_q   <= x_d;
      d1_res_q <= in_i;
    end
  end

  // d2: magnitude and sign
  logic [32:0] d2_a_q;
  logic        d2_neg_q;
  psc_res_t    d2_res_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      d2_neg_q <= d1_x_q[32];
      d2_a_q   <= d1_x_q[32] ? 33'(-d1_x_q) : 33'(d1_x_q);
      d2_res_q <= d1_res_q;
    end
  end

  // d3: quotient estimate by reciprocal, at most one below the true value
  logic [66:0] est_d;
  logic [32:0] d3_q0_q;
  logic [32:0] d3_a_q;
  logic        d3_neg_q;
  psc_res_t    d3_res_q;
  assign est_d = 67'(d2_a_q) * 67'(DepthRecip);

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      d3_q0_q  <= est_d[66:RecipShift];
      d3_a_q   <= d2_a_q;
      d3_neg_q <= d2_neg_q;
      d3_res_q <= d2_res_q;
    end
  end

  // d4: dividend and back-multiplied estimate
  logic [56:0] d4_pa_q;
  logic [56:0] d4_pq_q;
  logic [32:0] d4_q0_q;
  logic        d4_neg_q;
  psc_res_t    d4_res_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      d4_pa_q  <= 57'(d3_a_q) * 57'(DepthNum);
      d4_pq_q  <= 57'(d3_q0_q) * 57'(DepthDen);
      d4_q0_q  <= d3_q0_q;
      d4_neg_q <= d3_neg_q;
      d4_res_q <= d3_res_q;
    end
  end

  // d5: remainder below twice the divisor, one correction step
  logic [56:0] rem_full;
  logic [24:0] rem_d;
  logic [32:0] d5_q_q;
  logic        d5_neg_q;
  psc_res_t    d5_res_q;
  assign rem_full = d4_pa_q - d4_pq_q;
  assign rem_d    = rem_full[24:0];

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      d5_q_q   <= d4_q0_q + 33'(rem_d >= 25'(DepthDen));
      d5_neg_q <= d4_neg_q;
      d5_res_q <= d4_res_q;
    end
  end

  // d6: sign, saturation and output register
  logic signed [DepW-1:0] dep_d;
  logic [32:0]            negq;
  logic signed [DepW-1:0] d6_dep_q;
  psc_res_t               d6_res_q;
  assign negq = ~d5_q_q + 33'd1;

  always_comb begin
    if (d5_neg_q) begin
      dep_d = (d5_q_q > 33'h080000000) ? 32'sh80000000 : $signed(negq[31:0]);
    end else begin
      dep_d = (d5_q_q > 33'h07fffffff) ? 32'sh7fffffff : $signed(d5_q_q[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      d6_dep_q <= dep_d;
      d6_res_q <= d5_res_q;
    end
  end

  assign out_o   = d6_res_q;
  assign depth_o = d6_dep_q;

endmodule

/* sv/pressure_sensor_compensation_core.sv */
// second-order compensated temperature, pressure and depth from raw sensor conversions
// path: a result is valid once its request has passed 11 + 6 register stages
// throughput: one request per cycle unless res_o stalls; each stage has its own valid bit
// and a stalled output only holds stages that carry data, so empty ones take new requests
// reset: clears all valid bits, calibration words go to zero and sea_ref to 10133
module pressure_sensor_compensation_core import psc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  psc_smp_if.sink          smp_i,
  psc_res_if.source        res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int unsigned NumStg = 11;

  // configuration registers
  logic [CalW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [SeaW-1:0] sea_ref_q;
  logic            cfg_wr;
  psc_reg_e        reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = psc_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q      <= '0;
      c2_q      <= '0;
      c3_q      <= '0;
      c4_q      <= '0;
      c5_q      <= '0;
      c6_q      <= '0;
      sea_ref_q <= SeaW'(10133);
    end else if (cfg_wr) begin
      case (reg_sel)
        RegC1:     c1_q      <= pwdata[CalW-1:0];
        RegC2:     c2_q      <= pwdata[CalW-1:0];
        RegC3:     c3_q      <= pwdata[CalW-1:0];
        RegC4:     c4_q      <= pwdata[CalW-1:0];
        RegC5:     c5_q      <= pwdata[CalW-1:0];
        RegC6:     c6_q      <= pwdata[CalW-1:0];
        RegSeaRef: sea_ref_q <= pwdata[SeaW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegC1:     prdata = DataW'(c1_q);
      RegC2:     prdata = DataW'(c2_q);
      RegC3:     prdata = DataW'(c3_q);
      RegC4:     prdata = DataW'(c4_q);
      RegC5:     prdata = DataW'(c5_q);
      RegC6:     prdata = DataW'(c6_q);
      RegSeaRef: prdata = DataW'(sea_ref_q);
      default:   prdata = '0;
    endcase
  end

  // stage handshake
  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] vld_in;
  logic [NumStg:0]   rdy;
  logic              dep_ready;

  assign rdy[NumStg] = dep_ready;
  for (genvar g = 0; g < NumStg; g++) begin : g_rdy
    assign rdy[g] = ~vld_q[g] | rdy[g+1];
  end
  assign vld_in      = {vld_q[NumStg-2:0], smp_i.valid};
  assign smp_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (rdy[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  // s1: dt = d2 - c5 * 256
  logic signed [24:0] dt_d;
  logic signed [24:0] s1_dt_q;
  logic [RawW-1:0]    s1_d1_q;
  assign dt_d = $signed({1'b0, smp_i.raw_temperature}) - $signed({1'b0, c5_q, 8'h00});

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_dt_q <= dt_d;
      s1_d1_q <= smp_i.raw_pressure;
    end
  end

  // s2: first-order products and dt squared
  logic signed [49:0] dd_full;
  logic signed [41:0] s2_m6_q, s2_m4_q, s2_m3_q;
  logic [47:0]        s2_dd_q;
  logic [RawW-1:0]    s2_d1_q;
  assign dd_full = 50'(s1_dt_q) * 50'(s1_dt_q);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_m6_q <= 42'(s1_dt_q) * 42'($signed({1'b0, c6_q}));
      s2_m4_q <= 42'(s1_dt_q) * 42'($signed({1'b0, c4_q}));
      s2_m3_q <= 42'(s1_dt_q) * 42'($signed({1'b0, c3_q}));
      s2_dd_q <= dd_full[47:0];
      s2_d1_q <= s1_d1_q;
    end
  end

  // s3: truncating shifts, offset and sensitivity, branch flags
  logic signed [18:0] tdev_d;
  logic [34:0]        m4t_d;
  logic [33:0]        m3t_d;
  logic signed [35:0] off1_d, sens1_d;
  logic [49:0]        dd3_d;
  logic               low_d, vlow_d;
  logic [16:0]        ti_d;

  // truncation toward zero: floor plus one when negative with bits shifted out
  assign tdev_d  = $signed(s2_m6_q[41:23] + 19'(s2_m6_q[41] & (|s2_m6_q[22:0])));
  assign m4t_d   = s2_m4_q[41:7] + 35'(s2_m4_q[41] & (|s2_m4_q[6:0]));
  assign m3t_d   = s2_m3_q[41:8] + 34'(s2_m3_q[41] & (|s2_m3_q[7:0]));
  assign off1_d  = $signed({4'b0, c2_q, 16'h0000}) + 36'($signed(m4t_d));
  assign sens1_d = $signed({5'b0, c1_q, 15'h0000}) + 36'($signed(m3t_d));
  assign low_d   = tdev_d[18];
  assign vlow_d  = tdev_d < -19'sd3500;
  assign dd3_d   = {2'b00, s2_dd_q} + {1'b0, s2_dd_q, 1'b0};
  assign ti_d    = low_d ? dd3_d[49:33] : {5'b0, s2_dd_q[47:36]};

  logic signed [18:0] s3_tdev_q, s3_vl_q;
  logic signed [35:0] s3_off1_q, s3_sens1_q;
  logic [16:0]        s3_ti_q;
  logic               s3_low_q, s3_vlow_q;
  logic [RawW-1:0]    s3_d1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s3_tdev_q  <= tdev_d;
      s3_vl_q    <= tdev_d + 19'sd3500;
      s3_off1_q  <= off1_d;
      s3_sens1_q <= sens1_d;
      s3_ti_q    <= ti_d;
      s3_low_q   <= low_d;
      s3_vlow_q  <= vlow_d;
      s3_d1_q    <= s2_d1_q;
    end
  end

  // s4: squares of the temperature deviations
  logic signed [37:0] tsq_full, vsq_full;
  logic [35:0]        s4_tsq_q, s4_vsq_q;
  logic signed [18:0] s4_tdev_q;
  logic signed [35:0] s4_off1_q, s4_sens1_q;
  logic [16:0]        s4_ti_q;
  logic               s4_low_q, s4_vlow_q;
  logic [RawW-1:0]    s4_d1_q;
  assign tsq_full = 38'(s3_tdev_q) * 38'(s3_tdev_q);
  assign vsq_full = 38'(s3_vl_q) * 38'(s3_vl_q);

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s4_tsq_q   <= tsq_full[35:0];
      s4_vsq_q   <= vsq_full[35:0];
      s4_tdev_q  <= s3_tdev_q;
      s4_off1_q  <= s3_off1_q;
      s4_sens1_q <= s3_sens1_q;
      s4_ti_q    <= s3_ti_q;
      s4_low_q   <= s3_low_q;
      s4_vlow_q  <= s3_vlow_q;
      s4_d1_q    <= s3_d1_q;
    end
  end

  // s5: small constant multiples, final temperature
  logic [37:0]             s5_t3_q, s5_t5_q;
  logic [38:0]             s5_v7_q;
  logic [35:0]             s5_tsq_q, s5_vsq_q;
  logic signed [TempW-1:0] s5_temp_q;
  logic signed [35:0]      s5_off1_q, s5_sens1_q;
  logic                    s5_low_q, s5_vlow_q;
  logic [RawW-1:0]         s5_d1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s5_t3_q    <= {2'b00, s4_tsq_q} + {1'b0, s4_tsq_q, 1'b0};
      s5_t5_q    <= {2'b00, s4_tsq_q} + {s4_tsq_q, 2'b00};
      s5_v7_q    <= {s4_vsq_q, 3'b000} - {3'b000, s4_vsq_q};
      s5_tsq_q   <= s4_tsq_q;
      s5_vsq_q   <= s4_vsq_q;
      s5_temp_q  <= s4_tdev_q + 19'sd2000 - $signed({2'b00, s4_ti_q});
      s5_off1_q  <= s4_off1_q;
      s5_sens1_q <= s4_sens1_q;
      s5_low_q   <= s4_low_q;
      s5_vlow_q  <= s4_vlow_q;
      s5_d1_q    <= s4_d1_q;
    end
  end

  // s6: second-order offset and sensitivity corrections
  logic [38:0]             offi_d, sensi_d;
  logic [38:0]             s6_offi_q, s6_sensi_q;
  logic signed [TempW-1:0] s6_temp_q;
  logic signed [35:0]      s6_off1_q, s6_sens1_q;
  logic [RawW-1:0]         s6_d1_q;

  always_comb begin
    if (s5_low_q) begin
      offi_d  = {2'b00, s5_t3_q[37:1]} + (s5_vlow_q ? s5_v7_q : 39'd0);
      sensi_d = {4'b0000, s5_t5_q[37:3]} +
                (s5_vlow_q ? {1'b0, s5_vsq_q, 2'b00} : 39'd0);
    end else begin
      offi_d  = {7'b0, s5_tsq_q[35:4]};
      sensi_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s6_offi_q  <= offi_d;
      s6_sensi_q <= sensi_d;
      s6_temp_q  <= s5_temp_q;
      s6_off1_q  <= s5_off1_q;
      s6_sens1_q <= s5_sens1_q;
      s6_d1_q    <= s5_d1_q;
    end
  end

  // s7: corrected offset and sensitivity
  logic signed [39:0]      s7_off_q, s7_sens_q;
  logic signed [TempW-1:0] s7_temp_q;
  logic [RawW-1:0]         s7_d1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s7_off_q  <= 40'(s6_off1_q) - $signed({1'b0, s6_offi_q});
      s7_sens_q <= 40'(s6_sens1_q) - $signed({1'b0, s6_sensi_q});
      s7_temp_q <= s6_temp_q;
      s7_d1_q   <= s6_d1_q;
    end
  end

  // s8: d1 * sens split into a low unsigned and a high signed partial product
  logic [18:0]             sens_lo;
  logic signed [20:0]      sens_hi;
  logic [42:0]             s8_pl_q;
  logic signed [45:0]      s8_ph_q;
  logic signed [39:0]      s8_off_q;
  logic signed [TempW-1:0] s8_temp_q;
  assign sens_lo = s7_sens_q[18:0];
  assign sens_hi = s7_sens_q[39:19];

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      s8_pl_q   <= 43'(s7_d1_q) * 43'(sens_lo);
      s8_ph_q   <= 46'($signed({1'b0, s7_d1_q})) * 46'(sens_hi);
      s8_off_q  <= s7_off_q;
      s8_temp_q <= s7_temp_q;
    end
  end

  // s9: partial products recombined
  logic signed [63:0]      s9_prod_q;
  logic signed [39:0]      s9_off_q;
  logic signed [TempW-1:0] s9_temp_q;

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      s9_prod_q <= $signed({s8_ph_q[44:0], 19'h00000}) + $signed({21'b0, s8_pl_q});
      s9_off_q  <= s8_off_q;
      s9_temp_q <= s8_temp_q;
    end
  end

  // s10: trunc(prod / 2^21) - off
  logic [43:0]             y_d;
  logic signed [43:0]      s10_y_q;
  logic signed [TempW-1:0] s10_temp_q;
  assign y_d = 44'($signed(s9_prod_q[63:21])) - 44'(s9_off_q) +
               44'(s9_prod_q[63] & (|s9_prod_q[20:0]));

  always_ff @(posedge clk_i) begin
    if (rdy[9]) begin
      s10_y_q    <= $signed(y_d);
      s10_temp_q <= s9_temp_q;
    end
  end

  // s11: pressure = trunc(y / 2^13), always inside 31 bits
  logic [30:0] p31_d;
  psc_res_t    s11_res_q;
  assign p31_d = s10_y_q[43:13] + 31'(s10_y_q[43] & (|s10_y_q[12:0]));

  always_ff @(posedge clk_i) begin
    if (rdy[10]) begin
      s11_res_q.pressure <= 32'($signed(p31_d));
      s11_res_q.temp     <= s10_temp_q;
    end
  end

  // depth conversion and output register
  psc_res_t               res;
  logic signed [DepW-1:0] depth;

  psc_depth u_depth (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_q[NumStg-1]),
    .in_ready_o  (dep_ready),
    .in_i        (s11_res_q),
    .sea_ref_i   (sea_ref_q),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_o       (res),
    .depth_o     (depth)
  );

  assign res_o.temp_centi         = res.temp;
  assign res_o.pressure_deci_mbar = res.pressure;
  assign res_o.depth_mm           = depth;

endmodule

/* tb/sv/psc_compensation_checker.sv */
// request/result monitor with compensation predictor and scoreboard for the core
module psc_compensation_checker import psc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  psc_smp_if               smp_i,
  psc_res_if               res_i,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic [DataW-1:0] prdata,
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SeaRefReset = 10133;
  localparam longint TempRef     = 2000;
  localparam longint TempVeryLow = -1500;

  typedef struct {
    logic signed [TempW-1:0] temp;
    logic signed [PresW-1:0] pressure;
    logic signed [DepW-1:0]  depth;
  } reading_t;

  longint   cal [7];
  reading_t expected_readings [$];
  reading_t head;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[AddrW-1:2];

  function automatic longint sat_s32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // first-order terms, then the second-order correction by temperature branch
  function automatic reading_t compensate(logic [RawW-1:0] d1_raw, logic [RawW-1:0] d2_raw);
    longint d1, d2, dt, temp, off, sens, ti, offi, sensi, tdev, vl, p, depth;
    reading_t r;
    d1   = d1_raw;
    d2   = d2_raw;
    dt   = d2 - cal[RegC5] * 256;
    temp = TempRef + (dt * cal[RegC6]) / 8388608;
    off  = cal[RegC2] * 65536 + (cal[RegC4] * dt) / 128;
    sens = cal[RegC1] * 32768 + (cal[RegC3] * dt) / 256;
    tdev = temp - TempRef;
    if (temp < TempRef) begin
      ti    = (3 * dt * dt) / 64'sd8589934592;
      offi  = (3 * tdev * tdev) / 2;
      sensi = (5 * tdev * tdev) / 8;
      if (temp < TempVeryLow) begin
        vl    = temp - TempVeryLow;
        offi  += 7 * vl * vl;
        sensi += 4 * vl * vl;
      end
    end else begin
      ti    = (2 * dt * dt) / 64'sd137438953472;
      offi  = (tdev * tdev) / 16;
      sensi = 0;
    end
    temp  -= ti;
    off   -= offi;
    sens  -= sensi;
    p     = sat_s32(((d1 * sens) / 2097152 - off) / 8192);
    depth = sat_s32(((p - cal[RegSeaRef]) * 10000000) / 10091043);
    r.temp     = temp[TempW-1:0];
    r.pressure = p[PresW-1:0];
    r.depth    = depth[DepW-1:0];
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (cal[i]) cal[i] = 0;
      cal[RegSeaRef] = SeaRefReset;
      expected_readings.delete();
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pready && reg_idx <= RegSeaRef) begin
        if (pwrite) begin
          cal[reg_idx] = (reg_idx == RegSeaRef) ? longint'(pwdata[SeaW-1:0])
                                                : longint'(pwdata[CalW-1:0]);
        end else if (longint'(prdata) !== cal[reg_idx]) begin
          note_mismatch($sformatf("register %0d read %0d expected %0d",
                                  reg_idx, prdata, cal[reg_idx]));
        end
      end
      // retire before accepting so a result never pairs with a same-cycle request
      if (res_i.valid && res_i.ready) begin
        if (expected_readings.size() == 0) begin
          note_mismatch($sformatf("result with no request pending (temp %0d)",
                                  res_i.temp_centi));
        end else begin
          head = expected_readings.pop_front();
          if (res_i.temp_centi !== head.temp)
            note_mismatch($sformatf("temp_centi got %0d expected %0d",
                                    res_i.temp_centi, head.temp));
          if (res_i.pressure_deci_mbar !== head.pressure)
            note_mismatch($sformatf("pressure_deci_mbar got %0d expected %0d",
                                    res_i.pressure_deci_mbar, head.pressure));
          if (res_i.depth_mm !== head.depth)
            note_mismatch($sformatf("depth_mm got %0d expected %0d",
                                    res_i.depth_mm, head.depth));
        end
      end
      if (smp_i.valid && smp_i.ready)
        expected_readings.push_back(compensate(smp_i.raw_pressure, smp_i.raw_temperature));
      pending_o <= expected_readings.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
// stimulus, calibration sequencing and verdict for the pressure compensation core
module tb import psc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  RegUnmapped  = 3'd7;
  localparam int unsigned RawMax       = (1 << RawW) - 1;
  localparam int          DrainCap     = 5000;
  localparam int          SettleCycles = 24;
  localparam int          BatchLen     = 65;

  typedef enum {CalTypical, CalZero, CalFull, CalRandom, CalMixed} cal_profile_e;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic             pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               errors;
  int               pending;
  logic [SeaW-1:0]  cal_word [7];

  psc_smp_if smp ();
  psc_res_if res ();

  pressure_sensor_compensation_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .smp_i   (smp),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  psc_compensation_checker chk (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .smp_i     (smp),
    .res_i     (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // setup then access; ends on the completing edge with the bus released
  task automatic apb_access(logic wr, logic [2:0] idx, logic [DataW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_calibration(cal_profile_e profile);
    logic [DataW-1:0] junk;
    for (int i = 0; i <= int'(RegSeaRef); i++) begin
      case (profile)
        CalTypical: cal_word[i] = '0;
        CalZero:    cal_word[i] = '0;
        CalFull:    cal_word[i] = (i == int'(RegSeaRef)) ? 20'hFFFFF : 20'h0FFFF;
        CalRandom:  cal_word[i] = (i == int'(RegSeaRef)) ? 20'($urandom_range(20'hFFFFF))
                                                         : 20'($urandom_range(16'hFFFF));
        default:    cal_word[i] = (i % 2 == 0) ? 20'h0FFFF : 20'h0;
      endcase
    end
    if (profile == CalTypical) begin
      cal_word[RegC1]     = 20'd34982;
      cal_word[RegC2]     = 20'd36352;
      cal_word[RegC3]     = 20'd20328;
      cal_word[RegC4]     = 20'd22354;
      cal_word[RegC5]     = 20'd26646;
      cal_word[RegC6]     = 20'd26146;
      cal_word[RegSeaRef] = 20'd10133;
    end
    // upper bits carry junk; the core must keep only the register width
    for (int i = 0; i <= int'(RegSeaRef); i++) begin
      junk = $urandom();
      junk = (i == int'(RegSeaRef)) ? {junk[DataW-1:SeaW], cal_word[i]}
                                    : {junk[DataW-1:CalW], cal_word[i][CalW-1:0]};
      apb_access(1'b1, 3'(i), junk);
    end
    apb_access(1'b1, RegUnmapped, $urandom());
    for (int i = 0; i <= int'(RegSeaRef); i++) apb_access(1'b0, 3'(i), '0);
  endtask

  task automatic send_sample(logic [RawW-1:0] d1, logic [RawW-1:0] d2);
    while ($urandom_range(99) < tx_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid           <= 1'b1;
    smp.raw_pressure    <= d1;
    smp.raw_temperature <= d2;
    do @(posedge clk); while (!smp.ready);
  endtask

  // raw extremes and bit patterns, then temperature boundaries around the reference, the low and the very-low branch
  task automatic directed_samples();
    longint c5s;
    longint c6;
    longint vl_dt;
    longint offs [11];
    c5s   = longint'(cal_word[RegC5]) * 256;
    c6    = longint'(cal_word[RegC6]);
    vl_dt = -(longint'(3500) * 8388608) / c6;
    offs  = '{0, 1, -1, -320, -321, -65536, 1 << 20, vl_dt, vl_dt - 1000, vl_dt + 1000, -c5s};
    send_sample('0, '0);
    send_sample(RawW'(RawMax), RawW'(RawMax));
    send_sample(RawW'(RawMax), '0);
    send_sample('0, RawW'(RawMax));
    send_sample(24'hAAAAAA, 24'h555555);
    send_sample(24'h555555, 24'hAAAAAA);
    foreach (offs[i]) send_sample(24'd4311823, RawW'(c5s + offs[i]));
  endtask

  task automatic random_samples(int count);
    logic [RawW-1:0] d1;
    logic [RawW-1:0] d2;
    longint          near;
    for (int k = 0; k < count; k++) begin
      d1 = RawW'($urandom_range(RawMax));
      d2 = RawW'($urandom_range(RawMax));
      case ($urandom_range(3))
        1: begin
          // around the reference temperature, both branches
          near = longint'(cal_word[RegC5]) * 256 + longint'($urandom_range(1 << 19)) - (1 << 18);
          if (near < 0) near = 0;
          if (near > RawMax) near = RawMax;
          d2 = RawW'(near);
        end
        2: d2 = $urandom_range(1) ? RawW'($urandom_range(4095))
                                  : RawW'(RawMax - $urandom_range(4095));
        3: d1 = $urandom_range(1) ? RawW'($urandom_range(4095))
                                  : RawW'(RawMax - $urandom_range(4095));
        default: ;
      endcase
      send_sample(d1, d2);
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    smp.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DrainCap);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_batch(cal_profile_e profile);
    program_calibration(profile);
    random_samples(BatchLen);
    drain();
  endtask

  initial begin
    smp.valid           = 1'b0;
    smp.raw_pressure    = '0;
    smp.raw_temperature = '0;
    res.ready           = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    tx_idle_pct         = 0;
    rx_idle_pct         = 0;
    rst_n               = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset values read back before any write
    for (int i = 0; i <= int'(RegSeaRef); i++) apb_access(1'b0, 3'(i), '0);

    tx_idle_pct = 12;
    rx_idle_pct = 45;
    program_calibration(CalTypical);
    directed_samples();
    random_samples(BatchLen);
    drain();
    run_batch(CalZero);

    tx_idle_pct = 45;
    rx_idle_pct = 12;
    run_batch(CalFull);
    run_batch(CalRandom);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_batch(CalRandom);
    run_batch(CalMixed);

    if (errors == 0 && pending == 0) begin
      $display("PASS pressure_sensor_compensation_core");
    end else begin
      $display("FAIL pressure_sensor_compensation_core");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL pressure_sensor_compensation_core");
    $finish;
  end

endmodule
